@@ rtl/core/tps_pkg.sv @@
`default_nettype none
package tps_pkg;

    // Queue between the classifying front and the splitting back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Arithmetic widths.
    localparam int DW     = 36;          // signed plane distance
    localparam int NRM_W  = 31;          // Q1.30 normal component
    localparam int DIF_W  = 33;          // coordinate difference
    localparam int PRD_W  = 64;          // normal times difference
    localparam int SUM_W  = 66;          // sum of three products
    localparam int SHIFT  = 30;          // normal fraction bits
    localparam int DEN_W  = 37;          // crossing denominator
    localparam int HALF_W = 18;          // split of the distance magnitude
    localparam int PP_W   = HALF_W + DIF_W;
    localparam int NUM_W  = 68;          // crossing numerator magnitude
    localparam int QBITS  = 44;          // quotient bits developed
    localparam int DIV_STEPS = 4;        // quotient bits per cycle
    localparam int DIV_CYC   = QBITS / DIV_STEPS;
    localparam int DCW       = $clog2(DIV_CYC);
    localparam int QLIM_LOG  = 40;       // quotient clamp is 2^40
    localparam int Q_W       = QLIM_LOG + 1;
    localparam int RES_W     = 43;

    localparam logic [Q_W-1:0] Q_LIM = {1'b1, {QLIM_LOG{1'b0}}};

    localparam logic signed [NRM_W-1:0] NZ_RESET = 31'h3FFF_FFFF;

    typedef logic signed [31:0]    t_coord;
    typedef logic signed [DW-1:0]  t_dist;
    typedef logic signed [NRM_W-1:0] t_ncomp;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_ncomp x;
        t_ncomp y;
        t_ncomp z;
    } t_nrm;

    typedef enum logic [1:0] {
        K_UP   = 2'd0,
        K_DOWN = 2'd1,
        K_SEG  = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        M_NONE,
        M_SEG,
        M_TRI,
        M_SPLIT
    } t_mode;

    typedef enum logic [2:0] {
        A_NX = 3'd0,
        A_NY = 3'd1,
        A_NZ = 3'd2,
        A_PX = 3'd3,
        A_PY = 3'd4,
        A_PZ = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CROSS1,
        B_CROSS2,
        B_EMIT
    } t_back_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_MLO,
        D_MHI,
        D_SUM,
        D_DIV,
        D_RND,
        D_ADD
    } t_div_state;

    // One classified triangle as handed from the front to the back.
    typedef struct packed {
        logic  face_en;
        t_kind face_kind;
        t_mode mode;
        t_kind tri_kind;
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_vec  v;
        t_vec  v1;
        t_vec  v2;
        t_dist dv;
        t_dist d1;
        t_dist d2;
    } t_item;

    typedef struct packed {
        t_kind kind;
        t_vec  p;
        t_vec  q;
        t_vec  r;
        logic  last;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/core/tps_front.sv @@
`default_nettype none
module tps_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  tps_pkg::t_vec      i_a,
    input  tps_pkg::t_vec      i_b,
    input  tps_pkg::t_vec      i_c,
    input  tps_pkg::t_nrm      i_nrm,
    input  tps_pkg::t_vec      i_pnt,
    output logic               o_push,
    output tps_pkg::t_item     o_item
);

    function automatic tps_pkg::t_coord axis(tps_pkg::t_vec v, int k);
        case (k)
            0:       return v.x;
            1:       return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic prod_ge(tps_pkg::t_dist x, tps_pkg::t_dist y);
        return !((x != '0) && (y != '0) && (x[tps_pkg::DW-1] != y[tps_pkg::DW-1]));
    endfunction

    logic                                r_v1, r_v2, r_v3;
    logic signed [tps_pkg::DIF_W-1:0]    r_s1_df [0:8];
    logic signed [tps_pkg::PRD_W-1:0]    r_s2_pr [0:8];
    tps_pkg::t_dist                      r_s3_d  [0:2];
    tps_pkg::t_vec                       r_s1_vtx [0:2];
    tps_pkg::t_vec                       r_s2_vtx [0:2];
    tps_pkg::t_vec                       r_s3_vtx [0:2];
    tps_pkg::t_vec                       w_in [0:2];
    tps_pkg::t_ncomp                     w_n  [0:2];
    logic signed [tps_pkg::SUM_W-1:0]    w_sum [0:2];

    assign w_in[0] = i_a;
    assign w_in[1] = i_b;
    assign w_in[2] = i_c;
    assign w_n[0]  = i_nrm.x;
    assign w_n[1]  = i_nrm.y;
    assign w_n[2]  = i_nrm.z;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Offsets from the plane point, then products with the normal.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_s1_vtx[j] <= w_in[j];
            r_s2_vtx[j] <= r_s1_vtx[j];
            r_s3_vtx[j] <= r_s2_vtx[j];
            for (int k = 0; k < 3; k++) begin
                r_s1_df[3*j+k] <= 33'(axis(w_in[j], k)) - 33'(axis(i_pnt, k));
                r_s2_pr[3*j+k] <= r_s1_df[3*j+k] * w_n[k];
            end
        end
    end

    // Distance is the floor of the dot product over 2^30.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum[j] = 66'(r_s2_pr[3*j]) + 66'(r_s2_pr[3*j+1]) + 66'(r_s2_pr[3*j+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_s3_d[j] <= w_sum[j][tps_pkg::SUM_W-1:tps_pkg::SHIFT];
        end
    end

    // Face filing and the pairwise sign analysis.
    always_comb begin
        logic z0, z1, z2, n0, n1, n2, p0, p1, p2;
        logic s0z, s1z, s2z, s0n, s1p, s2p;
        logic apex_en;
        tps_pkg::t_dist dv, d1, d2;
        tps_pkg::t_vec  v, v1, v2;

        z0 = (r_s3_d[0] == '0);
        z1 = (r_s3_d[1] == '0);
        z2 = (r_s3_d[2] == '0);
        n0 = r_s3_d[0][tps_pkg::DW-1];
        n1 = r_s3_d[1][tps_pkg::DW-1];
        n2 = r_s3_d[2][tps_pkg::DW-1];
        p0 = !z0 && !n0;
        p1 = !z1 && !n1;
        p2 = !z2 && !n2;
        s0z = z0 || z1;
        s1z = z1 || z2;
        s2z = z0 || z2;
        s0n = !s0z && (n0 != n1);
        s1p = !s1z && (n1 == n2);
        s2p = !s2z && (n0 == n2);

        o_item.a = r_s3_vtx[0];
        o_item.b = r_s3_vtx[1];
        o_item.c = r_s3_vtx[2];
        o_item.face_en   = !(z0 && z1 && z2) && ((!n0 && !n1 && !n2) || (!p0 && !p1 && !p2));
        o_item.face_kind = (!n0 && !n1 && !n2) ? tps_pkg::K_UP : tps_pkg::K_DOWN;

        apex_en = 1'b0;
        v  = r_s3_vtx[2];
        v1 = r_s3_vtx[0];
        v2 = r_s3_vtx[1];
        dv = r_s3_d[2];
        d1 = r_s3_d[0];
        d2 = r_s3_d[1];
        o_item.mode     = tps_pkg::M_NONE;
        o_item.tri_kind = tps_pkg::K_UP;

        if (s0z && s1z && s2z) begin
            // An edge lying in the plane gives a segment when the third vertex is above.
            if (z0 && z1 && p2) begin
                o_item.mode = tps_pkg::M_SEG;
                v  = r_s3_vtx[0];
                v1 = r_s3_vtx[1];
            end else if (z0 && p1 && z2) begin
                o_item.mode = tps_pkg::M_SEG;
                v  = r_s3_vtx[2];
                v1 = r_s3_vtx[0];
            end else if (p0 && z1 && z2) begin
                o_item.mode = tps_pkg::M_SEG;
                v  = r_s3_vtx[1];
                v1 = r_s3_vtx[2];
            end
        end else if (!s0n && (!s1p || !s2p)) begin
            apex_en = 1'b1;
        end else if (s0n && !s1p) begin
            apex_en = 1'b1;
            v  = r_s3_vtx[1];
            v1 = r_s3_vtx[2];
            v2 = r_s3_vtx[0];
            dv = r_s3_d[1];
            d1 = r_s3_d[2];
            d2 = r_s3_d[0];
        end else if (s0n && !s2p) begin
            apex_en = 1'b1;
            v  = r_s3_vtx[0];
            v1 = r_s3_vtx[1];
            v2 = r_s3_vtx[2];
            dv = r_s3_d[0];
            d1 = r_s3_d[1];
            d2 = r_s3_d[2];
        end

        // With the apex known, keep the whole triangle, split it, or yield nothing.
        if (apex_en) begin
            if (((d1 == '0) && prod_ge(dv, d2)) || ((d2 == '0) && prod_ge(dv, d1))) begin
                o_item.mode     = tps_pkg::M_TRI;
                o_item.tri_kind = dv[tps_pkg::DW-1] ? tps_pkg::K_DOWN : tps_pkg::K_UP;
            end else if (dv == '0) begin
                if (d1 != '0) begin
                    o_item.mode     = tps_pkg::M_TRI;
                    o_item.tri_kind = d1[tps_pkg::DW-1] ? tps_pkg::K_DOWN : tps_pkg::K_UP;
                end
            end else begin
                o_item.mode = tps_pkg::M_SPLIT;
            end
        end

        o_item.v  = v;
        o_item.v1 = v1;
        o_item.v2 = v2;
        o_item.dv = dv;
        o_item.d1 = d1;
        o_item.d2 = d2;
    end

    assign o_push = r_v3;

endmodule
`default_nettype wire

@@ rtl/core/tps_fifo.sv @@
`default_nettype none
module tps_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  tps_pkg::t_item i_item,
    input  wire logic      i_pop,
    output tps_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);

    tps_pkg::t_item               r_mem [0:tps_pkg::QDEPTH-1];
    logic [tps_pkg::QAW-1:0]      r_wptr, r_rptr;
    logic [tps_pkg::QCW-1:0]      r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == tps_pkg::QCW'(tps_pkg::QDEPTH));

endmodule
`default_nettype wire

@@ rtl/core/tps_xdiv.sv @@
`default_nettype none
module tps_xdiv (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  tps_pkg::t_coord i_v,
    input  tps_pkg::t_coord i_w,
    input  tps_pkg::t_dist  i_dv,
    input  tps_pkg::t_dist  i_dw,
    output logic            o_done,
    output tps_pkg::t_coord o_c
);

    tps_pkg::t_div_state               r_state, n_state;
    logic signed [tps_pkg::DEN_W-1:0]  w_den;
    logic signed [tps_pkg::DIF_W-1:0]  w_dif;
    logic [tps_pkg::DEN_W-1:0]         r_dm;
    logic [tps_pkg::DW-1:0]            r_dvm;
    logic [tps_pkg::DIF_W-1:0]         r_fm;
    logic [tps_pkg::PP_W-1:0]          r_plo, r_phi;
    logic [tps_pkg::NUM_W-1:0]         w_num;
    logic [tps_pkg::DEN_W-1:0]         r_rem, w_rem;
    logic [tps_pkg::QBITS-1:0]         r_quo, w_quo;
    logic [tps_pkg::QBITS:0]           w_qr;
    logic [tps_pkg::Q_W-1:0]           r_q;
    logic signed [tps_pkg::RES_W-1:0]  w_res;
    logic [tps_pkg::DCW-1:0]           r_cnt;
    logic                              r_sat, r_neg, r_zero, r_done;
    tps_pkg::t_coord                   r_v, r_c;

    assign w_den = 37'(i_dv) - 37'(i_dw);
    assign w_dif = 33'(i_w) - 33'(i_v);
    assign w_num = 68'(r_plo) + (68'(r_phi) << tps_pkg::HALF_W);

    // Four restoring division steps per cycle.
    always_comb begin
        logic [tps_pkg::DEN_W:0] t;
        w_rem = r_rem;
        w_quo = r_quo;
        for (int s = 0; s < tps_pkg::DIV_STEPS; s++) begin
            t     = {w_rem, w_quo[tps_pkg::QBITS-1]};
            w_quo = {w_quo[tps_pkg::QBITS-2:0], 1'b0};
            if (t >= {1'b0, r_dm}) begin
                t        = t - {1'b0, r_dm};
                w_quo[0] = 1'b1;
            end
            w_rem = t[tps_pkg::DEN_W-1:0];
        end
    end

    // Round half away from zero, then apply the sign.
    assign w_qr  = {1'b0, r_quo} + 45'({r_rem, 1'b0} >= {1'b0, r_dm});
    assign w_res = 43'(r_v) + (r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q}));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tps_pkg::D_IDLE: if (i_start) n_state = tps_pkg::D_MLO;
            tps_pkg::D_MLO:  n_state = tps_pkg::D_MHI;
            tps_pkg::D_MHI:  n_state = tps_pkg::D_SUM;
            tps_pkg::D_SUM:  n_state = tps_pkg::D_DIV;
            tps_pkg::D_DIV: begin
                if (r_cnt == tps_pkg::DCW'(tps_pkg::DIV_CYC - 1)) n_state = tps_pkg::D_RND;
            end
            tps_pkg::D_RND:  n_state = tps_pkg::D_ADD;
            tps_pkg::D_ADD:  n_state = tps_pkg::D_IDLE;
            default:         n_state = tps_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tps_pkg::D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == tps_pkg::D_ADD);
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tps_pkg::D_IDLE: begin
                r_v    <= i_v;
                r_zero <= (w_den == '0);
                r_neg  <= i_dv[tps_pkg::DW-1] ^ w_dif[tps_pkg::DIF_W-1] ^ w_den[tps_pkg::DEN_W-1];
                r_dvm  <= i_dv[tps_pkg::DW-1] ? (~i_dv + 1'b1) : i_dv;
                r_fm   <= w_dif[tps_pkg::DIF_W-1] ? (~w_dif + 1'b1) : w_dif;
                r_dm   <= w_den[tps_pkg::DEN_W-1] ? (~w_den + 1'b1) : w_den;
            end
            tps_pkg::D_MLO: r_plo <= r_dvm[tps_pkg::HALF_W-1:0] * r_fm;
            tps_pkg::D_MHI: r_phi <= r_dvm[tps_pkg::DW-1:tps_pkg::HALF_W] * r_fm;
            tps_pkg::D_SUM: begin
                r_rem <= 37'(w_num[tps_pkg::NUM_W-1:tps_pkg::QBITS]);
                r_quo <= w_num[tps_pkg::QBITS-1:0];
                r_sat <= 37'(w_num[tps_pkg::NUM_W-1:tps_pkg::QBITS]) >= r_dm;
                r_cnt <= '0;
            end
            tps_pkg::D_DIV: begin
                r_rem <= w_rem;
                r_quo <= w_quo;
                r_cnt <= r_cnt + 1'b1;
            end
            tps_pkg::D_RND: begin
                if (r_sat || (w_qr > (45'(1) << tps_pkg::QLIM_LOG))) begin
                    r_q <= tps_pkg::Q_LIM;
                end else begin
                    r_q <= w_qr[tps_pkg::Q_W-1:0];
                end
            end
            tps_pkg::D_ADD: begin
                if (r_zero) begin
                    r_c <= r_v;
                end else if (w_res > 43'sh0_7FFF_FFFF) begin
                    r_c <= 32'sh7FFF_FFFF;
                end else if (w_res < -43'sh0_8000_0000) begin
                    r_c <= 32'sh8000_0000;
                end else begin
                    r_c <= w_res[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_c    = r_c;

endmodule
`default_nettype wire

@@ rtl/core/tps_back.sv @@
`default_nettype none
module tps_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  tps_pkg::t_item     i_head,
    output logic               o_pop,
    output logic               o_valid,
    output tps_pkg::t_result   o_res
);

    tps_pkg::t_back_state r_state, n_state;
    tps_pkg::t_item       r_item;
    tps_pkg::t_vec        r_c1, r_c2, w_c, w_w;
    tps_pkg::t_dist       w_dw;
    tps_pkg::t_result     w_res, r_res;
    logic [2:0]           r_k, w_total, w_j;
    logic                 r_go, w_go, w_last, w_can_load, r_valid;
    logic                 w_dx, w_dy, w_dz, w_xdone;

    // Crossing units, one per axis.
    assign w_w  = (r_state == tps_pkg::B_CROSS2) ? r_item.v2 : r_item.v1;
    assign w_dw = (r_state == tps_pkg::B_CROSS2) ? r_item.d2 : r_item.d1;
    assign w_go = r_go && ((r_state == tps_pkg::B_CROSS1) || (r_state == tps_pkg::B_CROSS2));

    tps_xdiv u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_go),
        .i_v(r_item.v.x), .i_w(w_w.x), .i_dv(r_item.dv), .i_dw(w_dw),
        .o_done(w_dx), .o_c(w_c.x)
    );
    tps_xdiv u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_go),
        .i_v(r_item.v.y), .i_w(w_w.y), .i_dv(r_item.dv), .i_dw(w_dw),
        .o_done(w_dy), .o_c(w_c.y)
    );
    tps_xdiv u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_go),
        .i_v(r_item.v.z), .i_w(w_w.z), .i_dv(r_item.dv), .i_dw(w_dw),
        .o_done(w_dz), .o_c(w_c.z)
    );

    // The three axis units run in lock step.
    assign w_xdone = w_dx && w_dy && w_dz;

    // Result list of the current triangle.
    always_comb begin
        logic up;
        up = !r_item.dv[tps_pkg::DW-1];
        w_total = 3'(r_item.face_en);
        case (r_item.mode)
            tps_pkg::M_SEG, tps_pkg::M_TRI: w_total = w_total + 3'd1;
            tps_pkg::M_SPLIT:               w_total = w_total + 3'd4;
            default: ;
        endcase
        w_last = (w_total == 3'd0) || (r_k == w_total - 3'd1);
        w_j    = r_k - 3'(r_item.face_en);

        w_res      = '0;
        w_res.kind = tps_pkg::K_NONE;
        w_res.last = w_last;
        if (w_total == 3'd0) begin
            w_res.kind = tps_pkg::K_NONE;
        end else if (r_item.face_en && (r_k == 3'd0)) begin
            w_res.kind = r_item.face_kind;
            w_res.p    = r_item.a;
            w_res.q    = r_item.b;
            w_res.r    = r_item.c;
        end else begin
            case (r_item.mode)
                tps_pkg::M_SEG: begin
                    w_res.kind = tps_pkg::K_SEG;
                    w_res.p    = r_item.v;
                    w_res.q    = r_item.v1;
                end
                tps_pkg::M_TRI: begin
                    w_res.kind = r_item.tri_kind;
                    w_res.p    = r_item.v;
                    w_res.q    = r_item.v1;
                    w_res.r    = r_item.v2;
                end
                tps_pkg::M_SPLIT: begin
                    case (w_j)
                        3'd0: begin
                            w_res.kind = up ? tps_pkg::K_UP : tps_pkg::K_DOWN;
                            w_res.p    = r_item.v;
                            w_res.q    = r_c1;
                            w_res.r    = r_c2;
                        end
                        3'd1: begin
                            w_res.kind = up ? tps_pkg::K_DOWN : tps_pkg::K_UP;
                            w_res.p    = r_c2;
                            w_res.q    = r_c1;
                            w_res.r    = r_item.v2;
                        end
                        3'd2: begin
                            w_res.kind = up ? tps_pkg::K_DOWN : tps_pkg::K_UP;
                            w_res.p    = r_c1;
                            w_res.q    = r_item.v1;
                            w_res.r    = r_item.v2;
                        end
                        default: begin
                            w_res.kind = tps_pkg::K_SEG;
                            w_res.p    = up ? r_c1 : r_c2;
                            w_res.q    = up ? r_c2 : r_c1;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Next state and queue pop.
    always_comb begin
        w_can_load = (r_state == tps_pkg::B_IDLE) || ((r_state == tps_pkg::B_EMIT) && w_last);
        o_pop      = w_can_load && !i_empty;
        n_state    = r_state;
        case (r_state)
            tps_pkg::B_IDLE: begin
                if (o_pop) begin
                    n_state = (i_head.mode == tps_pkg::M_SPLIT) ? tps_pkg::B_CROSS1
                                                                : tps_pkg::B_EMIT;
                end
            end
            tps_pkg::B_CROSS1: if (w_xdone) n_state = tps_pkg::B_CROSS2;
            tps_pkg::B_CROSS2: if (w_xdone) n_state = tps_pkg::B_EMIT;
            tps_pkg::B_EMIT: begin
                if (w_last) begin
                    if (o_pop) begin
                        n_state = (i_head.mode == tps_pkg::M_SPLIT) ? tps_pkg::B_CROSS1
                                                                    : tps_pkg::B_EMIT;
                    end else begin
                        n_state = tps_pkg::B_IDLE;
                    end
                end
            end
            default: n_state = tps_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tps_pkg::B_IDLE;
            r_valid <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == tps_pkg::B_EMIT);
            if (o_pop) begin
                r_go <= (i_head.mode == tps_pkg::M_SPLIT);
            end else if ((r_state == tps_pkg::B_CROSS1) && w_xdone) begin
                r_go <= 1'b1;
            end else if (w_go) begin
                r_go <= 1'b0;
            end
        end
    end

    // Item, crossing points, result counter and output register.
    always_ff @(posedge i_clk) begin
        if ((r_state == tps_pkg::B_CROSS1) && w_xdone) begin
            r_c1 <= w_c;
        end
        if ((r_state == tps_pkg::B_CROSS2) && w_xdone) begin
            r_c2 <= w_c;
        end
        if (r_state == tps_pkg::B_EMIT) begin
            r_res <= w_res;
        end
        if (o_pop) begin
            r_item <= i_head;
            r_k    <= 3'd0;
        end else if (r_state == tps_pkg::B_EMIT) begin
            r_k    <= r_k + 3'd1;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

@@ rtl/core/triangle_plane_splitter.sv @@
`default_nettype none
// Triangle plane splitter: a triangle taken on start passes the front's offset, product and
// distance registers into the queue and, with the back idle, its first result is then registered in the
// back's output register. The back sends one result per cycle while it emits, one to five per
// triangle; a cut triangle first runs two crossing computations, one after the other. Busy is
// high while four triangles are in the front and queue. Synchronous active-low reset empties
// the pipeline and queue and restores the plane.
module triangle_plane_splitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_c_x,
    input  wire logic signed [31:0] i_c_y,
    input  wire logic signed [31:0] i_c_z,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic signed [31:0] o_p_x,
    output logic signed [31:0] o_p_y,
    output logic signed [31:0] o_p_z,
    output logic signed [31:0] o_q_x,
    output logic signed [31:0] o_q_y,
    output logic signed [31:0] o_q_z,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    tps_pkg::t_nrm              r_nrm;
    tps_pkg::t_vec              r_pnt;
    logic [tps_pkg::QCW-1:0]    r_credit;
    logic                       w_take, w_push, w_pop, w_empty, w_full, w_wr;
    tps_pkg::t_item             w_item, w_head;
    tps_pkg::t_result           w_res;
    tps_pkg::t_vec              w_a, w_b, w_c;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Plane registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm.x <= '0;
            r_nrm.y <= '0;
            r_nrm.z <= tps_pkg::NZ_RESET;
            r_pnt   <= '0;
        end else if (w_wr) begin
            case (tps_pkg::t_reg'(paddr[4:2]))
                tps_pkg::A_NX: r_nrm.x <= pwdata[tps_pkg::NRM_W-1:0];
                tps_pkg::A_NY: r_nrm.y <= pwdata[tps_pkg::NRM_W-1:0];
                tps_pkg::A_NZ: r_nrm.z <= pwdata[tps_pkg::NRM_W-1:0];
                tps_pkg::A_PX: r_pnt.x <= pwdata;
                tps_pkg::A_PY: r_pnt.y <= pwdata;
                tps_pkg::A_PZ: r_pnt.z <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (tps_pkg::t_reg'(paddr[4:2]))
            tps_pkg::A_NX: prdata = 32'(r_nrm.x);
            tps_pkg::A_NY: prdata = 32'(r_nrm.y);
            tps_pkg::A_NZ: prdata = 32'(r_nrm.z);
            tps_pkg::A_PX: prdata = r_pnt.x;
            tps_pkg::A_PY: prdata = r_pnt.y;
            tps_pkg::A_PZ: prdata = r_pnt.z;
            default:       prdata = '0;
        endcase
    end

    // Credits cover the front pipeline and the queue together.
    assign busy   = (r_credit == tps_pkg::QCW'(tps_pkg::QDEPTH));
    assign w_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (w_take && !w_pop) begin
            r_credit <= r_credit + 1'b1;
        end else if (!w_take && w_pop) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    assign w_a = '{x: i_a_x, y: i_a_y, z: i_a_z};
    assign w_b = '{x: i_b_x, y: i_b_y, z: i_b_z};
    assign w_c = '{x: i_c_x, y: i_c_y, z: i_c_z};

    tps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_a(w_a), .i_b(w_b), .i_c(w_c), .i_nrm(r_nrm), .i_pnt(r_pnt),
        .o_push(w_push), .o_item(w_item)
    );

    tps_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(w_item),
        .i_pop(w_pop), .o_head(w_head), .o_empty(w_empty), .o_full(w_full)
    );

    tps_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_head(w_head),
        .o_pop(w_pop), .o_valid(o_valid), .o_res(w_res)
    );

    assign o_kind = w_res.kind;
    assign o_p_x  = w_res.p.x;
    assign o_p_y  = w_res.p.y;
    assign o_p_z  = w_res.p.z;
    assign o_q_x  = w_res.q.x;
    assign o_q_y  = w_res.q.y;
    assign o_q_z  = w_res.q.z;
    assign o_r_x  = w_res.r.x;
    assign o_r_y  = w_res.r.y;
    assign o_r_z  = w_res.r.z;
    assign o_last = w_res.last;

    // The credit scheme must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full || w_pop)
        else $error("queue written while full");

    // A triangle that yields nothing closes with its single marker.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (w_res.kind == tps_pkg::K_NONE) |-> o_last)
        else $error("empty marker without last");

    // Segments carry no third point.
    a_seg_r_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (w_res.kind == tps_pkg::K_SEG) |-> (w_res.r == '0))
        else $error("segment with third point set");

endmodule
`default_nettype wire
